/* src/bprq_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the button press repeat qualifier.
package bprq_pkg;

   localparam int QueueDepthDefault = 8;
   localparam int NumButtonsDefault = 4;
   localparam int MaxButtons        = 4;

   localparam int CountWidth = 12;
   localparam int CodeWidth  = 4;
   localparam int MaskWidth  = 4;
   localparam int PendWidth  = 3;
   localparam int CsrIdxWidth = 3;

   localparam logic [CountWidth-1:0] COUNT_MAX = '1;

   // Opcodes of an input transfer
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE      = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_LONG_PRESS    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_REPEAT_START  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_REPEAT_PERIOD = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_IMMEDIATE     = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_LONG_ENABLE   = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_REPEAT_ENABLE = 3'd6;

   // Register reset values
   localparam logic [CountWidth-1:0] DEBOUNCE_RESET      = 12'd2;
   localparam logic [CountWidth-1:0] LONG_PRESS_RESET    = 12'd120;
   localparam logic [CountWidth-1:0] REPEAT_START_RESET  = 12'd60;
   localparam logic [CountWidth-1:0] REPEAT_PERIOD_RESET = 12'd16;
   localparam logic [MaskWidth-1:0]  IMMEDIATE_RESET     = 4'd3;
   localparam logic [MaskWidth-1:0]  LONG_ENABLE_RESET   = 4'd12;
   localparam logic [MaskWidth-1:0]  REPEAT_ENABLE_RESET = 4'd3;

   // Event codes
   localparam logic [CodeWidth-1:0] EV_NONE = 4'd0;
   localparam logic [CodeWidth-1:0] PRESS_CODES [MaxButtons] = '{4'd1, 4'd3, 4'd5, 4'd7};
   localparam logic [CodeWidth-1:0] HOLD_CODES  [MaxButtons] = '{4'd2, 4'd4, 4'd6, 4'd8};

   typedef struct packed {
      logic [CountWidth-1:0] debounce;
      logic [CountWidth-1:0] long_press;
      logic [CountWidth-1:0] repeat_start;
      logic [CountWidth-1:0] repeat_period;
      logic                  immediate;
      logic                  long_enable;
      logic                  repeat_enable;
   } btn_cfg_type;

   typedef struct packed {
      logic                 push;
      logic [CodeWidth-1:0] code;
   } push_req_type;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

/* src/bprq_button.sv */
`timescale 1ns / 1ps
// Per-button debounce, long press and auto-repeat state machine.
module bprq_button #(
   parameter int BTN_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick_en,
   input  logic                  level,
   input  bprq_pkg::btn_cfg_type cfg,
   output bprq_pkg::push_req_type push_req
);
   import bprq_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_PRESSED  = 2'd2,
      PH_HELD     = 2'd3
   } phase_type;

   localparam logic [CodeWidth-1:0] PRESS_CODE = PRESS_CODES[BTN_INDEX];
   localparam logic [CodeWidth-1:0] HOLD_CODE  = HOLD_CODES[BTN_INDEX];

   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] phase_cnt_ff, phase_cnt_in;
   logic [CountWidth-1:0] hold_cnt_ff, hold_cnt_in;
   logic [CountWidth-1:0] phase_inc, hold_inc;

   always_comb begin
      phase_in      = phase_ff;
      phase_cnt_in  = phase_cnt_ff;
      hold_cnt_in   = hold_cnt_ff;
      phase_inc     = sat_inc(phase_cnt_ff);
      hold_inc      = sat_inc(hold_cnt_ff);
      push_req.push = 1'b0;
      push_req.code = EV_NONE;
      if (tick_en) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (level) begin
                  phase_in     = PH_DEBOUNCE;
                  phase_cnt_in = '0;
               end
            end
            PH_DEBOUNCE: begin
               if (!level) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_cnt_in = phase_inc;
                  if (phase_inc >= cfg.debounce) begin
                     phase_in      = PH_PRESSED;
                     hold_cnt_in   = '0;
                     push_req.push = cfg.immediate;
                     push_req.code = PRESS_CODE;
                  end
               end
            end
            PH_PRESSED: begin
               hold_cnt_in = hold_inc;
               if (!level) begin
                  phase_in      = PH_IDLE;
                  push_req.push = !cfg.immediate;
                  push_req.code = PRESS_CODE;
               end else if ((cfg.long_enable && hold_inc >= cfg.long_press) ||
                            (cfg.repeat_enable && hold_inc >= cfg.repeat_start)) begin
                  phase_in      = PH_HELD;
                  phase_cnt_in  = '0;
                  push_req.push = 1'b1;
                  push_req.code = HOLD_CODE;
               end
            end
            PH_HELD: begin
               if (!level) begin
                  phase_in = PH_IDLE;
               end else if (cfg.repeat_enable) begin
                  if (phase_inc >= cfg.repeat_period) begin
                     phase_cnt_in  = '0;
                     push_req.push = 1'b1;
                     push_req.code = HOLD_CODE;
                  end else begin
                     phase_cnt_in = phase_inc;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         phase_cnt_ff <= '0;
         hold_cnt_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         phase_cnt_ff <= phase_cnt_in;
         hold_cnt_ff  <= hold_cnt_in;
      end
   end

endmodule

/* src/bprq_queue.sv */
`timescale 1ns / 1ps
// Event ring buffer: several ordered pushes per tick, one pop per transfer.
module bprq_queue #(
   parameter int DEPTH    = 8,
   parameter int NUM_PUSH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                tick_en,
   input  logic                                pop_en,
   input  bprq_pkg::push_req_type [NUM_PUSH-1:0] push_reqs,
   output logic [bprq_pkg::CodeWidth-1:0]      pop_code,
   output logic [bprq_pkg::PendWidth-1:0]      pending
);
   import bprq_pkg::*;

   localparam int IdxWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ExtWidth = IdxWidth + 1;
   localparam logic [IdxWidth-1:0] LAST_SLOT = IdxWidth'(DEPTH - 1);

   logic [CodeWidth-1:0] store_ff [DEPTH];
   logic [CodeWidth-1:0] store_in [DEPTH];
   logic [IdxWidth-1:0]  wr_ff, wr_in;
   logic [IdxWidth-1:0]  rd_ff, rd_in;
   logic [IdxWidth-1:0]  nx;
   logic [ExtWidth-1:0]  fill;
   logic [ExtWidth+PendWidth-1:0] fill_x;

   function automatic logic [IdxWidth-1:0] next_slot(input logic [IdxWidth-1:0] i);
      next_slot = (i == LAST_SLOT) ? '0 : i + 1'b1;
   endfunction

   // Pushes go in button order; drop any that meets a full ring.
   always_comb begin
      store_in = store_ff;
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      nx       = '0;
      pop_code = EV_NONE;
      if (tick_en) begin
         for (int b = 0; b < NUM_PUSH; b++) begin
            nx = next_slot(wr_in);
            if (push_reqs[b].push && nx != rd_ff) begin
               store_in[wr_in] = push_reqs[b].code;
               wr_in           = nx;
            end
         end
      end
      if (pop_en && wr_ff != rd_ff) begin
         pop_code = store_ff[rd_ff];
         rd_in    = next_slot(rd_ff);
      end
   end

   assign fill = (wr_in >= rd_in) ? ExtWidth'(wr_in) - ExtWidth'(rd_in)
                                  : ExtWidth'(DEPTH) - ExtWidth'(rd_in) + ExtWidth'(wr_in);
   assign fill_x  = (ExtWidth+PendWidth)'(fill);
   assign pending = fill_x[PendWidth-1:0];

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

endmodule

/* src/button_press_repeat_qualifier_top.sv */
`timescale 1ns / 1ps
// Top level of the button press repeat qualifier.
//
// Request channel (req_*): each transfer carries an opcode and four button
// levels. A tick advances every button's debounce / press / hold machine and
// may queue press, long and repeat events in button order. A pop takes the
// oldest queued event.
// Response channel (rsp_*): exactly one response per request: the popped
// event code (0 for a tick or an empty pop) and the events still queued.
// The queue keeps QUEUE_DEPTH-1 events; a push into a full queue is dropped.
// Configuration (csr_*): single-cycle writes of thresholds and per-button
// masks, to be issued by the user only while the block is idle; the block does not enforce it.
//
// Timing: a request is registered on accept and evaluated in one pass into
// the response register, which raises rsp_valid; a stall on the response can
// hold the request in the input register in between. One request per cycle is
// sustained while rsp_ready stays high; the one-pass logic sets that.
// Reset: all buttons idle, counters zero, queue empty, registers at defaults.
// Stall: while rsp_ready is low the response holds; one more request waits in
// the input register, then req_ready drops.
module button_press_repeat_qualifier_top #(
   parameter int QUEUE_DEPTH = bprq_pkg::QueueDepthDefault,
   parameter int NUM_BUTTONS = bprq_pkg::NumButtonsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [bprq_pkg::MaskWidth-1:0]    req_button_levels,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bprq_pkg::CodeWidth-1:0]    rsp_event_code,
   output logic [bprq_pkg::PendWidth-1:0]    rsp_pending_count,
   input  logic                              csr_write_en,
   input  logic [bprq_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [bprq_pkg::CountWidth-1:0]   csr_wdata
);
   import bprq_pkg::*;

   // Configuration registers
   logic [CountWidth-1:0] debounce_ff, long_press_ff, repeat_start_ff, repeat_period_ff;
   logic [MaskWidth-1:0]  immediate_ff, long_enable_ff, repeat_enable_ff;

   // Input stage
   logic                 in_valid_ff, in_valid_in;
   logic                 in_opcode_ff;
   logic [MaskWidth-1:0] in_levels_ff;

   // Response stage
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CodeWidth-1:0] rsp_code_ff;
   logic [PendWidth-1:0] rsp_pend_ff;

   logic                 advance;
   logic                 tick_en;
   logic                 pop_en;
   logic [CodeWidth-1:0] pop_code;
   logic [PendWidth-1:0] pending;
   push_req_type [NUM_BUTTONS-1:0] push_reqs;

   // Move the held request forward whenever the response slot is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign tick_en   = advance && (in_opcode_ff == OP_TICK);
   assign pop_en    = advance && (in_opcode_ff == OP_POP);

   // Configuration writes; out-of-range indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff      <= DEBOUNCE_RESET;
         long_press_ff    <= LONG_PRESS_RESET;
         repeat_start_ff  <= REPEAT_START_RESET;
         repeat_period_ff <= REPEAT_PERIOD_RESET;
         immediate_ff     <= IMMEDIATE_RESET;
         long_enable_ff   <= LONG_ENABLE_RESET;
         repeat_enable_ff <= REPEAT_ENABLE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE:      debounce_ff      <= csr_wdata;
            CSR_LONG_PRESS:    long_press_ff    <= csr_wdata;
            CSR_REPEAT_START:  repeat_start_ff  <= csr_wdata;
            CSR_REPEAT_PERIOD: repeat_period_ff <= csr_wdata;
            CSR_IMMEDIATE:     immediate_ff     <= csr_wdata[MaskWidth-1:0];
            CSR_LONG_ENABLE:   long_enable_ff   <= csr_wdata[MaskWidth-1:0];
            CSR_REPEAT_ENABLE: repeat_enable_ff <= csr_wdata[MaskWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register: load on every request transfer, clear when consumed.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_opcode_ff <= req_opcode;
         in_levels_ff <= req_button_levels;
      end
   end

   // One state machine per button; buttons above NUM_BUTTONS do not exist.
   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_button
      btn_cfg_type cfg;

      assign cfg.debounce      = debounce_ff;
      assign cfg.long_press    = long_press_ff;
      assign cfg.repeat_start  = repeat_start_ff;
      assign cfg.repeat_period = repeat_period_ff;
      assign cfg.immediate     = immediate_ff[b];
      assign cfg.long_enable   = long_enable_ff[b];
      assign cfg.repeat_enable = repeat_enable_ff[b];

      bprq_button #(
         .BTN_INDEX (b)
      ) u_button (
         .clock    (clock),
         .reset    (reset),
         .tick_en  (tick_en),
         .level    (in_levels_ff[b]),
         .cfg      (cfg),
         .push_req (push_reqs[b])
      );
   end

   bprq_queue #(
      .DEPTH    (QUEUE_DEPTH),
      .NUM_PUSH (NUM_BUTTONS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .tick_en   (tick_en),
      .pop_en    (pop_en),
      .push_reqs (push_reqs),
      .pop_code  (pop_code),
      .pending   (pending)
   );

   // Response register: load on advance, drop valid once the transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_code_ff <= pop_code;
         rsp_pend_ff <= pending;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_code    = rsp_code_ff;
   assign rsp_pending_count = rsp_pend_ff;

endmodule
